>>> hw/rtl/binary_to_decimal_ascii_macros.svh
// ---------------------------------------------------------------------------
// Binary to decimal ASCII assertion macros
// Shared concurrent assertion forms for the converter's modules.
// ---------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define B2DA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define B2DA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/b2da_pkg.sv
// ---------------------------------------------------------------------------
// Binary to decimal ASCII package
// Widths, constants and defaults shared by the converter's modules.
// ---------------------------------------------------------------------------
package b2da_pkg;

   localparam int VALUE_W = 32;
   localparam int CHAR_W  = 6;
   localparam int DIGIT_W = 4;

   localparam int MAX_DIGITS_DEFAULT  = 10;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // ASCII '0'
   localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'h30;

   // Divide by ten: q = (v * RECIP_TEN) >> RECIP_SHIFT, exact for 32-bit v.
   localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                 RECIP_SHIFT = 35;

endpackage

>>> hw/rtl/binary_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// Binary to decimal ASCII converter
// Prints a 32-bit unsigned number as ASCII decimal digits, MSB first.
// ---------------------------------------------------------------------------
// Each request carries one unsigned number; the block answers with one
// response per decimal digit, most significant first, no leading zeros, and
// flags the least significant digit with rsp_is_last. Zero prints as a single
// '0'. If MAX_DIGITS is below the digit count of a number, only its low
// MAX_DIGITS digits come out (which may start with '0'). Both sides look like
// a queue: push/full on the request side, empty/pop on the response side.
// A number of n digits occupies the converter for one load, n
// divide-by-ten steps through a single reciprocal multiplier and n emit
// steps; an emit step waits while a held-off pop keeps the response full.
// A request queue of QUEUE_DEPTH entries takes new requests while the
// converter is busy, and a registered response stage keeps a stalled pop from
// stalling the request side until that queue fills.
// ---------------------------------------------------------------------------
module binary_to_decimal_ascii #(
   parameter int MAX_DIGITS  = b2da_pkg::MAX_DIGITS_DEFAULT,
   parameter int QUEUE_DEPTH = b2da_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // request side
   input  logic                         push,
   output logic                         full,
   input  logic [b2da_pkg::VALUE_W-1:0] req_value,
   // response side
   output logic                         empty,
   input  logic                         pop,
   output logic [b2da_pkg::CHAR_W-1:0]  rsp_ascii_char,
   output logic                         rsp_is_last
);

   // Queue head handed from front end to converter.
   logic                         head_valid;
   logic [b2da_pkg::VALUE_W-1:0] head_value;
   logic                         head_take;

   // Hold incoming requests until the converter is free.
   b2da_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_value  (req_value),
      .full       (full),
      .head_valid (head_valid),
      .head_value (head_value),
      .head_take  (head_take)
   );

   // Convert one number at a time and drive the response register.
   b2da_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_value     (head_value),
      .head_take      (head_take),
      .empty          (empty),
      .pop            (pop),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_is_last    (rsp_is_last)
   );

endmodule

>>> hw/rtl/b2da_front.sv
// ---------------------------------------------------------------------------
// Binary to decimal ASCII front end
// Accepts requests into a short queue that the conversion back end drains.
// ---------------------------------------------------------------------------
module b2da_front #(
   parameter int QUEUE_DEPTH = b2da_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [b2da_pkg::VALUE_W-1:0] req_value,
   output logic                         full,
   output logic                         head_valid,
   output logic [b2da_pkg::VALUE_W-1:0] head_value,
   input  logic                         head_take
);

   `include "binary_to_decimal_ascii_macros.svh"

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [b2da_pkg::VALUE_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_value = slot_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = head_take & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots: write only, no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= req_value;
      end
   end

   `B2DA_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
   `B2DA_ASSERT_NEXT(a_push_grows, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1, "push did not grow queue")
   `B2DA_ASSERT_NEXT(a_pop_shrinks, clock, reset, do_pop && !do_push, count_ff == $past(count_ff) - 1'b1, "pop did not shrink queue")

endmodule

>>> hw/rtl/b2da_back.sv
// ---------------------------------------------------------------------------
// Binary to decimal ASCII back end
// Peels decimal digits off by division by ten, then sends them out MSB first.
// ---------------------------------------------------------------------------
module b2da_back #(
   parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  logic [b2da_pkg::VALUE_W-1:0] head_value,
   output logic                         head_take,
   output logic                         empty,
   input  logic                         pop,
   output logic [b2da_pkg::CHAR_W-1:0]  rsp_ascii_char,
   output logic                         rsp_is_last
);

   `include "binary_to_decimal_ascii_macros.svh"

   localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int VW     = b2da_pkg::VALUE_W;
   localparam int PROD_W = 2 * VW;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   state_type                        state_ff, state_in;
   logic [VW-1:0]                    val_ff, val_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic [b2da_pkg::DIGIT_W-1:0]     digit_ff [MAX_DIGITS];
   logic                             out_valid_ff, out_valid_in;
   logic [b2da_pkg::CHAR_W-1:0]      out_char_ff, out_char_in;
   logic                             out_last_ff, out_last_in;

   logic [PROD_W-1:0]                prod;
   logic [VW-1:0]                    quot;
   logic [VW-1:0]                    rem;
   logic                             slot_free;

   // Reciprocal multiply by 0.1, then remainder from q*10 = q*8 + q*2.
   assign prod = {{VW{1'b0}}, val_ff} * {{VW{1'b0}}, b2da_pkg::RECIP_TEN};
   assign quot = VW'(prod >> b2da_pkg::RECIP_SHIFT);
   assign rem  = val_ff - ((quot << 3) + (quot << 1));

   assign slot_free = ~out_valid_ff | pop;

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff & ~pop;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      head_take    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               head_take = 1'b1;
               val_in    = head_value;
               idx_in    = '0;
               state_in  = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            val_in = quot;
            if (quot == '0 || idx_ff == IDX_W'(MAX_DIGITS - 1)) begin
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = b2da_pkg::DIGIT_BASE +
                              {{(b2da_pkg::CHAR_W - b2da_pkg::DIGIT_W){1'b0}}, digit_ff[idx_ff]};
               out_last_in  = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      val_ff      <= val_in;
      idx_ff      <= idx_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   // Digit buffer, least significant digit at index zero.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CONVERT) begin
         digit_ff[idx_ff] <= rem[b2da_pkg::DIGIT_W-1:0];
      end
   end

   assign empty          = ~out_valid_ff;
   assign rsp_ascii_char = out_char_ff;
   assign rsp_is_last    = out_last_ff;

   `B2DA_ASSERT_SAME(a_rem_digit, clock, reset, state_ff == ST_CONVERT, rem < VW'(10), "remainder is not a decimal digit")
   `B2DA_ASSERT_NEXT(a_emit_fills, clock, reset, state_ff == ST_EMIT && slot_free, out_valid_ff, "emit left output slot empty")
   `B2DA_ASSERT_NEXT(a_last_on_zero, clock, reset, state_ff == ST_EMIT && slot_free && idx_ff == '0, out_last_ff && state_ff == ST_IDLE, "final digit not flagged")
   `B2DA_ASSERT_SAME(a_take_idle, clock, reset, head_take, state_ff == ST_IDLE && !out_last_ff || state_ff == ST_IDLE, "request taken while busy")

endmodule

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// Binary to decimal ASCII converter testbench
// Sends unsigned numbers into the converter and checks every ASCII digit it
// returns, in order, against digits predicted locally by repeated division
// by ten. Both sides idle at random, and the response side holds off for
// long stretches so that the request side fills up and stalls.
// ---------------------------------------------------------------------------
module tb;

   localparam int VALUE_W      = b2da_pkg::VALUE_W;
   localparam int CHAR_W       = b2da_pkg::CHAR_W;
   localparam int DIGIT_W      = b2da_pkg::DIGIT_W;
   localparam logic [CHAR_W-1:0] DIGIT_BASE = b2da_pkg::DIGIT_BASE;

   localparam int MAX_DIGITS   = b2da_pkg::MAX_DIGITS_DEFAULT;
   localparam int RADIX        = 10;
   localparam int STACK_LEN    = 20;
   localparam int N_DIRECTED   = 20;
   localparam int N_RANDOM     = 450;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 40;

   // one expected response: a digit character and its end-of-number flag
   typedef struct packed {
      logic [CHAR_W-1:0] ascii_char;
      logic              is_last;
   } digit_type;

   // -------------------------------------------------------------------------
   // Digit scoreboard: predicts the digits of each accepted number and
   // checks responses against them in arrival order.
   // -------------------------------------------------------------------------
   class digit_scoreboard;
      int        cap;
      digit_type pending_digits[$];
      int        numbers_seen;
      int        digits_checked;
      int        mismatches;
      int        longest;

      function new(int max_digits);
         cap = (max_digits < 1) ? 1 : ((max_digits > STACK_LEN) ? STACK_LEN : max_digits);
         numbers_seen   = 0;
         digits_checked = 0;
         mismatches     = 0;
         longest        = 0;
      endfunction

      // Split the number into decimal digits, least significant first, then
      // queue them most significant first; stop once cap digits are taken.
      function void note_number(logic [VALUE_W-1:0] value);
         logic [DIGIT_W-1:0] digit_stack [STACK_LEN];
         logic [VALUE_W-1:0] rest;
         int                 n;
         digit_type          d;
         rest = value;
         n    = 0;
         if (rest == '0) begin
            digit_stack[0] = '0;
            n = 1;
         end else begin
            while (rest != '0 && n < cap) begin
               digit_stack[n] = DIGIT_W'(rest % RADIX);
               rest = rest / RADIX;
               n++;
            end
         end
         for (int k = 0; k < n; k++) begin
            d.ascii_char = DIGIT_BASE + CHAR_W'(digit_stack[n - 1 - k]);
            d.is_last    = (k == n - 1);
            pending_digits.push_back(d);
         end
         numbers_seen++;
         if (n > longest) longest = n;
      endfunction

      function void check_digit(logic [CHAR_W-1:0] ascii_char, logic is_last);
         digit_type want;
         if (pending_digits.size() == 0) begin
            $error("response char %h last %b with no digit pending", ascii_char, is_last);
            mismatches++;
            return;
         end
         want = pending_digits.pop_front();
         digits_checked++;
         if (ascii_char !== want.ascii_char) begin
            $error("rsp_ascii_char: expected %h, got %h", want.ascii_char, ascii_char);
            mismatches++;
         end
         if (is_last !== want.is_last) begin
            $error("rsp_is_last: expected %b, got %b", want.is_last, is_last);
            mismatches++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block under test
   // -------------------------------------------------------------------------
   logic               clock;
   logic               reset     = 1'b1;
   logic               push      = 1'b0;
   logic               pop       = 1'b0;
   logic [VALUE_W-1:0] req_value = '0;
   logic               full;
   logic               empty;
   logic [CHAR_W-1:0]  rsp_ascii_char;
   logic               rsp_is_last;

   digit_scoreboard sb = new(MAX_DIGITS);

   int idle_cycles = 0;
   int holds_done  = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   binary_to_decimal_ascii #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_value     (req_value),
      .empty         (empty),
      .pop           (pop),
      .rsp_ascii_char(rsp_ascii_char),
      .rsp_is_last   (rsp_is_last)
   );

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Return an idle gap: mostly none or short, now and then a long one.
   // In a steady stretch, return no gap at all.
   function automatic int pick_gap(bit steady);
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Pick a number: full 32-bit noise, tiny values, or a value of a random
   // digit count so that every length from one to ten digits shows up.
   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned       kind;
      int unsigned       ndig;
      longint unsigned   lo;
      longint unsigned   hi;
      kind = $urandom_range(0, 9);
      if (kind < 4) return $urandom;
      if (kind < 5) return $urandom_range(0, 20);
      ndig = $urandom_range(1, 10);
      lo   = 1;
      repeat (ndig - 1) lo = lo * RADIX;
      hi = lo * RADIX - 1;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      return VALUE_W'(lo + longint'($urandom) % (hi - lo + 1));
   endfunction

   // Offer one request after a random gap and hold it until accepted.
   // Enter and leave on a rising edge; push stays high between back-to-back
   // requests so it is never lowered and raised in the same step.
   task automatic send_number(input logic [VALUE_W-1:0] value, input bit steady);
      int gap;
      gap = pick_gap(steady);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push      <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (full);
   endtask

   // -------------------------------------------------------------------------
   // Monitor: sample both handshakes at the edge and feed the scoreboard.
   // Values read here are the ones the block saw at this edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) sb.note_number(req_value);
         if (pop && !empty) sb.check_digit(rsp_ascii_char, rsp_is_last);
      end
   end

   // Watchdog: end the run if nothing moves on either side for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response side: pop with random gaps. Twice, hold pop low for a long
   // stretch while the sender keeps offering, so the request queue fills and
   // full rises. Run a steady stretch with pop held high as well.
   // -------------------------------------------------------------------------
   initial begin
      int gap;
      int hold_marks [2];
      hold_marks = '{150, 1500};
      while (reset) @(posedge clock);
      forever begin
         if (holds_done < 2 && sb.digits_checked >= hold_marks[holds_done]) begin
            gap = HOLD_CYCLES;
            holds_done++;
         end else begin
            gap = pick_gap(sb.digits_checked >= 600 && sb.digits_checked < 1100);
         end
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
      end
   end

   // -------------------------------------------------------------------------
   // Request side and end of run
   // -------------------------------------------------------------------------
   initial begin
      logic [VALUE_W-1:0] directed_values [N_DIRECTED];
      // zero, one- and two-digit edges, powers of ten and their neighbors,
      // the largest 32-bit values, the sign-bit edge and alternating bits
      directed_values = '{
         32'd0, 32'd1, 32'd9, 32'd10, 32'd0, 32'd11, 32'd99, 32'd100, 32'd101,
         32'd999999999, 32'd1000000000, 32'd1000000001, 32'd4294967295,
         32'd4294967294, 32'd4294967290, 32'd2147483647, 32'd2147483648,
         32'hAAAA_AAAA, 32'h5555_5555, 32'd4000000000
      };

      // hold reset, then release it at a clock edge
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_values[i]) send_number(directed_values[i], 1'b0);

      // random part; run a stretch back to back with no sender gaps
      for (int i = 0; i < N_RANDOM; i++) begin
         send_number(pick_value(), i >= 200 && i < 280);
      end

      // drop push, let the monitor note the last request, then drain
      push <= 1'b0;
      @(posedge clock);
      while (sb.pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d numbers (%0d directed), %0d digits checked, up to %0d digits each",
               sb.numbers_seen, N_DIRECTED, sb.digits_checked, sb.longest);
      $display("response side held off %0d times for %0d cycles each", holds_done, HOLD_CYCLES);
      if (sb.mismatches == 0 && sb.pending_digits.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/b2da_pkg.sv
hw/rtl/b2da_front.sv
hw/rtl/b2da_back.sv
hw/rtl/binary_to_decimal_ascii.sv
tb/tb.sv
